@@ hw/rtl/interpolation_interval_locate_unit_macros.svh @@
// Assertion macros for the interpolation interval locate unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef INTERPOLATION_INTERVAL_LOCATE_UNIT_MACROS_SVH
`define INTERPOLATION_INTERVAL_LOCATE_UNIT_MACROS_SVH

// Plain property, sampled on clk_i and disabled during reset.
`define IILU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define IILU_ASSERT_IMP(lbl, ante, cons, msg) \
  `IILU_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/iilu_pkg.sv @@
// Package for the interpolation interval locate unit: constants, codes,
// the sequencer state type and the bracket test. No dependencies.
`default_nettype none

package iilu_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned WEIGHT_W       = 32;
  localparam int unsigned LEN_W          = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned FRAC_BITS      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRAPOLATE   = 2'd2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOCATE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FA,
    S_FB,
    S_TEST,
    S_XA,
    S_XB,
    S_XT,
    S_DIV,
    S_DONE
  } state_e;

  // True when x lies between a and b inclusive, in either order.
  function automatic logic between(input logic signed [COORD_W-1:0] a,
                                   input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] b);
    between = ((a >= x) && (x >= b)) || ((a <= x) && (x <= b));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/interpolation_interval_locate_unit.sv @@
// Interpolation interval locate unit: source coordinate store, bracket search
// sequencer and restoring divider for the Q16.16 weight. Uses iilu_pkg.
// A load beat is written in the accept cycle and returns no result. A locate
// beat does two store reads and a test per tested interval, refetches interval 0
// when it falls back to it as not found, first reads both end points when it
// extrapolates, then runs the divider (skipped for a zero divisor) and the output
// state; the strobe is in the cycle after that. busy_o drops as the strobe rises,
// so the next beat may be accepted at the edge that ends the strobe cycle.
// Reset clears control and registers (length 2, missing 0, extrapolate 0); the
// store is not cleared. The receiver cannot stall.
`default_nettype none

module interpolation_interval_locate_unit #(
  parameter int unsigned MAX_POINTS = iilu_pkg::MAX_POINTS_DEF,
  localparam int unsigned AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 req_type_i,
  input  wire logic [AW-1:0]                        load_index_i,
  input  wire logic signed [iilu_pkg::COORD_W-1:0]  coord_value_i,
  input  wire logic                                 first_target_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [iilu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [iilu_pkg::COORD_W-1:0]         cfg_wdata_i,
  output logic                                      result_valid_o,
  output logic [AW-1:0]                             interval_index_o,
  output logic                                      not_found_o,
  output logic signed [iilu_pkg::WEIGHT_W-1:0]      weight_o,
  output logic                                      weight_error_o
);

  localparam int unsigned CW    = iilu_pkg::COORD_W;
  localparam int unsigned NW    = (AW + 1 > iilu_pkg::LEN_W) ? AW + 1 : iilu_pkg::LEN_W;
  localparam int unsigned MW    = CW + 1;                    // magnitude width
  localparam int unsigned DVW   = MW + iilu_pkg::FRAC_BITS;  // dividend width
  localparam int unsigned CNTW  = $clog2(DVW + 1);

  // Configuration registers.
  logic [iilu_pkg::LEN_W-1:0] len_q;
  logic signed [CW-1:0]       miss_q;
  logic                       ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= iilu_pkg::LEN_W'(2);
      miss_q <= '0;
      ext_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iilu_pkg::REG_SOURCE_LENGTH: len_q  <= cfg_wdata_i[iilu_pkg::LEN_W-1:0];
        iilu_pkg::REG_MISSING_VALUE: miss_q <= cfg_wdata_i;
        iilu_pkg::REG_EXTRAPOLATE:   ext_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Effective length clamped into [2, MAX_POINTS]; last is the top interval.
  logic [NW-1:0] len_ext, n_eff, n_m2;
  logic [AW-1:0] last;
  always_comb begin
    len_ext = NW'(len_q);
    if (len_ext < NW'(2)) n_eff = NW'(2);
    else if (len_ext > NW'(MAX_POINTS)) n_eff = NW'(MAX_POINTS);
    else n_eff = len_ext;
    n_m2 = n_eff - NW'(2);
    last = n_m2[AW-1:0];
  end

  iilu_pkg::state_e state_q, state_d;
  logic accept, do_load;
  assign busy_o  = (state_q != iilu_pkg::S_IDLE);
  assign accept  = start_i && !busy_o;
  assign do_load = accept && (req_type_i == iilu_pkg::REQ_LOAD);

  // Search bookkeeping.
  logic signed [CW-1:0] t_q, a_q;
  logic [AW-1:0]        i_q, il_q, ir_q, prev_q;
  logic                 down_q, scan_q, fin_q, nf_q;

  // Source coordinate store: one write port, one registered read port.
  logic signed [CW-1:0] mem_q [MAX_POINTS];
  logic signed [CW-1:0] rdata_q;
  logic [AW-1:0]        raddr;
  logic [AW:0]          load_ext;
  assign load_ext = {1'b0, load_index_i};

  always_ff @(posedge clk_i) begin
    if (do_load && (load_ext < (AW+1)'(MAX_POINTS))) begin
      mem_q[load_index_i] <= coord_value_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // Bracket tests on the fetched pair.
  logic hit, miss_pair, x_low;
  assign miss_pair = (a_q == miss_q) || (rdata_q == miss_q);
  assign hit   = iilu_pkg::between(a_q, t_q, rdata_q) && !(scan_q && miss_pair);
  assign x_low = iilu_pkg::between(t_q, a_q, rdata_q);

  // Outward step choice.
  logic step_dn, step_up;
  assign step_dn = (il_q != '0) && (down_q || (ir_q == last));
  assign step_up = (ir_q < last) && (!down_q || (il_q == '0));

  // Divider.
  logic [MW-1:0]   num, den, den_q;
  logic            nneg, dneg, neg_q, zden_q, nzero_q;
  logic [DVW-1:0]  dvd_q;
  logic [MW-1:0]   rem_q;
  logic [CNTW-1:0] cnt_q;
  logic [MW:0]     rem_sh;
  logic            ge;

  always_comb begin
    nneg = (a_q < t_q);
    dneg = (a_q < rdata_q);
    num  = nneg ? (MW'(t_q) - MW'(a_q)) : (MW'(a_q) - MW'(t_q));
    den  = dneg ? (MW'(rdata_q) - MW'(a_q)) : (MW'(a_q) - MW'(rdata_q));
    rem_sh = {rem_q, dvd_q[DVW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  logic finish_test;
  assign finish_test = (state_q == iilu_pkg::S_TEST) && (fin_q || hit);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      iilu_pkg::S_IDLE: if (accept && (req_type_i == iilu_pkg::REQ_LOCATE)) begin
        state_d = iilu_pkg::S_FA;
      end
      iilu_pkg::S_FA: state_d = iilu_pkg::S_FB;
      iilu_pkg::S_FB: state_d = iilu_pkg::S_TEST;
      iilu_pkg::S_TEST: begin
        if (fin_q || hit) begin
          state_d = (den == '0) ? iilu_pkg::S_DONE : iilu_pkg::S_DIV;
        end else if (scan_q) begin
          if (i_q == last) state_d = ext_q ? iilu_pkg::S_XA : iilu_pkg::S_FA;
          else state_d = iilu_pkg::S_FA;
        end else if (step_dn || step_up) begin
          state_d = iilu_pkg::S_FA;
        end else begin
          state_d = ext_q ? iilu_pkg::S_XA : iilu_pkg::S_FA;
        end
      end
      iilu_pkg::S_XA: state_d = iilu_pkg::S_XB;
      iilu_pkg::S_XB: state_d = iilu_pkg::S_XT;
      iilu_pkg::S_XT: state_d = iilu_pkg::S_FA;
      iilu_pkg::S_DIV: if (cnt_q == CNTW'(1)) state_d = iilu_pkg::S_DONE;
      iilu_pkg::S_DONE: state_d = iilu_pkg::S_IDLE;
      default: state_d = iilu_pkg::S_IDLE;
    endcase
  end

  // Store read address per state.
  always_comb begin
    case (state_q)
      iilu_pkg::S_FA: raddr = i_q;
      iilu_pkg::S_FB: raddr = i_q + AW'(1);
      iilu_pkg::S_XA: raddr = '0;
      iilu_pkg::S_XB: raddr = last + AW'(1);
      default:        raddr = i_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iilu_pkg::S_IDLE;
      prev_q  <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      result_valid_o <= (state_q == iilu_pkg::S_DONE);
      if (finish_test) prev_q <= i_q;
    end
  end

  // Datapath registers.
  logic [AW-1:0] start_i_idx;
  assign start_i_idx = (prev_q > last) ? last : prev_q;

  logic [CW-1:0] q_lo;
  logic          q_big_pos, q_big_neg;
  assign q_lo      = dvd_q[CW-1:0];
  assign q_big_pos = (dvd_q > DVW'(32'h7FFF_FFFF));
  assign q_big_neg = (dvd_q > DVW'(32'h8000_0000));

  always_ff @(posedge clk_i) begin
    case (state_q)
      iilu_pkg::S_IDLE: begin
        t_q    <= coord_value_i;
        scan_q <= first_target_i;
        fin_q  <= 1'b0;
        nf_q   <= 1'b0;
        down_q <= 1'b1;
        if (first_target_i) begin
          i_q <= '0;
        end else begin
          i_q <= start_i_idx;
        end
        il_q <= start_i_idx;
        ir_q <= start_i_idx;
      end
      iilu_pkg::S_FB: a_q <= rdata_q;
      iilu_pkg::S_XB: a_q <= rdata_q;
      iilu_pkg::S_TEST: begin
        if (fin_q || hit) begin
          den_q   <= den;
          zden_q  <= (den == '0);
          nzero_q <= (num != '0);
          neg_q   <= (num != '0) && (nneg != dneg);
          dvd_q   <= {num, iilu_pkg::FRAC_BITS'(0)};
          rem_q   <= '0;
          cnt_q   <= CNTW'(DVW);
        end else if (scan_q) begin
          if (i_q == last) begin
            if (!ext_q) begin
              nf_q <= 1'b1;
              fin_q <= 1'b1;
              i_q  <= '0;
            end
          end else begin
            i_q <= i_q + AW'(1);
          end
        end else if (step_dn) begin
          il_q   <= il_q - AW'(1);
          i_q    <= il_q - AW'(1);
          down_q <= 1'b0;
        end else if (step_up) begin
          ir_q   <= ir_q + AW'(1);
          i_q    <= ir_q + AW'(1);
          down_q <= 1'b1;
        end else if (!ext_q) begin
          nf_q  <= 1'b1;
          fin_q <= 1'b1;
          i_q   <= '0;
        end
      end
      iilu_pkg::S_XT: begin
        fin_q <= 1'b1;
        i_q   <= x_low ? '0 : last;
      end
      iilu_pkg::S_DIV: begin
        rem_q <= ge ? MW'(rem_sh - {1'b0, den_q}) : rem_sh[MW-1:0];
        dvd_q <= {dvd_q[DVW-2:0], ge};
        cnt_q <= cnt_q - CNTW'(1);
      end
      iilu_pkg::S_DONE: begin
        interval_index_o <= nf_q ? '0 : i_q;
        not_found_o      <= nf_q;
        if (zden_q) begin
          weight_error_o <= 1'b1;
          if (!nzero_q) weight_o <= '0;
          else weight_o <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (neg_q) begin
          weight_error_o <= q_big_neg;
          weight_o       <= q_big_neg ? 32'sh8000_0000 : -$signed(q_lo);
        end else begin
          weight_error_o <= q_big_pos;
          weight_o       <= q_big_pos ? 32'sh7FFF_FFFF : $signed(q_lo);
        end
      end
      default: ;
    endcase
  end

`include "interpolation_interval_locate_unit_macros.svh"

  `IILU_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o, "result strobe repeated")
  `IILU_ASSERT_IMP(a_nf_index, result_valid_o && not_found_o, interval_index_o == '0, "nf idx")
  `IILU_ASSERT_IMP(a_test_range, state_q == iilu_pkg::S_TEST, i_q <= last, "interval beyond last")
  `IILU_ASSERT(a_locate_busy, (accept && req_type_i == iilu_pkg::REQ_LOCATE) |=> busy_o, "not busy")

endmodule

`default_nettype wire
